// ===== hdl/iclp_pkg.sv =====
// iclp_pkg: constants, phase codes and character lookups for the ICE
// candidate line parser. No dependencies.

package iclp_pkg;

   // Characters
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   // Length of the "candidate:" lead text
   localparam logic [3:0] LEAD_LEN = 4'd10;
   // Length of the "typ" token
   localparam logic [2:0] TYP_LEN  = 3'd3;
   // Field count at which the address field begins
   localparam logic [2:0] ADDR_FIELD = 3'd5;

   // Prefixed-form phase codes
   localparam logic [3:0] PH_SKIP      = 4'd0;
   localparam logic [3:0] PH_SKIP_SP   = 4'd1;
   localparam logic [3:0] PH_ADDR      = 4'd2;
   localparam logic [3:0] PH_PORT_SP   = 4'd3;
   localparam logic [3:0] PH_PORT      = 4'd4;
   localparam logic [3:0] PH_TOK_START = 4'd5;
   localparam logic [3:0] PH_TOK_MATCH = 4'd6;
   localparam logic [3:0] PH_TOK_SKIP  = 4'd7;
   localparam logic [3:0] PH_TYPE_WS   = 4'd8;
   localparam logic [3:0] PH_W_HOST    = 4'd9;
   localparam logic [3:0] PH_W_SRFLX   = 4'd10;
   localparam logic [3:0] PH_W_PRFLX   = 4'd11;
   localparam logic [3:0] PH_W_RELAY   = 4'd12;
   localparam logic [3:0] PH_DONE      = 4'd13;

   // Simple-form phase codes
   localparam logic [1:0] SP_ADDR   = 2'd0;
   localparam logic [1:0] SP_SPACES = 2'd1;
   localparam logic [1:0] SP_PORT   = 2'd2;
   localparam logic [1:0] SP_DONE   = 2'd3;

   // Candidate kinds
   localparam logic [1:0] KIND_HOST  = 2'd0;
   localparam logic [1:0] KIND_SRFLX = 2'd1;
   localparam logic [1:0] KIND_RELAY = 2'd2;

   // Type word selectors
   localparam logic [1:0] WORD_HOST  = 2'd0;
   localparam logic [1:0] WORD_SRFLX = 2'd1;
   localparam logic [1:0] WORD_PRFLX = 2'd2;
   localparam logic [1:0] WORD_RELAY = 2'd3;

   // "candidate:" character at a given index
   function automatic logic [7:0] lead_char(input logic [3:0] idx);
      logic [7:0] ch;
      case (idx)
         4'd0:    ch = "c";
         4'd1:    ch = "a";
         4'd2:    ch = "n";
         4'd3:    ch = "d";
         4'd4:    ch = "i";
         4'd5:    ch = "d";
         4'd6:    ch = "a";
         4'd7:    ch = "t";
         4'd8:    ch = "e";
         4'd9:    ch = ":";
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   // "typ" character at a given index
   function automatic logic [7:0] typ_char(input logic [2:0] idx);
      logic [7:0] ch;
      case (idx)
         3'd0:    ch = "t";
         3'd1:    ch = "y";
         3'd2:    ch = "p";
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   // Type word characters; host is padded with a zero
   function automatic logic [7:0] word_char(input logic [1:0] w, input logic [2:0] idx);
      logic [7:0] ch;
      ch = 8'h00;
      case (w)
         WORD_HOST: begin
            case (idx)
               3'd0:    ch = "h";
               3'd1:    ch = "o";
               3'd2:    ch = "s";
               3'd3:    ch = "t";
               default: ch = 8'h00;
            endcase
         end
         WORD_SRFLX: begin
            case (idx)
               3'd0:    ch = "s";
               3'd1:    ch = "r";
               3'd2:    ch = "f";
               3'd3:    ch = "l";
               3'd4:    ch = "x";
               default: ch = 8'h00;
            endcase
         end
         WORD_PRFLX: begin
            case (idx)
               3'd0:    ch = "p";
               3'd1:    ch = "r";
               3'd2:    ch = "f";
               3'd3:    ch = "l";
               3'd4:    ch = "x";
               default: ch = 8'h00;
            endcase
         end
         default: begin
            case (idx)
               3'd0:    ch = "r";
               3'd1:    ch = "e";
               3'd2:    ch = "l";
               3'd3:    ch = "a";
               3'd4:    ch = "y";
               default: ch = 8'h00;
            endcase
         end
      endcase
      return ch;
   endfunction

   function automatic logic [2:0] word_len(input logic [1:0] w);
      return (w == WORD_HOST) ? 3'd4 : 3'd5;
   endfunction

   function automatic logic [1:0] word_kind(input logic [1:0] w);
      logic [1:0] k;
      case (w)
         WORD_HOST:  k = KIND_HOST;
         WORD_SRFLX: k = KIND_SRFLX;
         WORD_PRFLX: k = KIND_SRFLX;
         default:    k = KIND_RELAY;
      endcase
      return k;
   endfunction

   function automatic logic is_ws(input logic [7:0] ch);
      return (ch == CHAR_SPACE) || (ch == CHAR_TAB);
   endfunction

   function automatic logic is_digit(input logic [7:0] ch);
      return (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
   endfunction

   function automatic logic [15:0] sat_inc16(input logic [15:0] v);
      return (v == 16'hFFFF) ? v : 16'(v + 16'd1);
   endfunction

   function automatic logic [5:0] sat_inc6(input logic [5:0] v);
      return (v == 6'd63) ? v : 6'(v + 6'd1);
   endfunction

   // port * 10 + digit, modulo 65536 (shift-add, no multiplier)
   function automatic logic [15:0] port_add(input logic [15:0] p, input logic [7:0] ch);
      return 16'({p[12:0], 3'b000} + {p[14:0], 1'b0} + {12'd0, ch[3:0]});
   endfunction

endpackage

// ===== hdl/iclp_if.sv =====
// iclp_if: valid/ready stream interfaces for the line parser's request
// (line bytes) and response (parse result) channels. No dependencies.

interface iclp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] line_byte;
   logic       last_byte;

   modport source (output valid, output line_byte, output last_byte, input ready);
   modport sink   (input valid, input line_byte, input last_byte, output ready);
endinterface

interface iclp_rsp_if;
   logic        valid;
   logic        ready;
   logic        status;
   logic        prefixed_form;
   logic [15:0] address_offset;
   logic [5:0]  address_length;
   logic [15:0] port_number;
   logic [1:0]  candidate_kind;

   modport source (output valid, output status, output prefixed_form,
                   output address_offset, output address_length,
                   output port_number, output candidate_kind, input ready);
   modport sink   (input valid, input status, input prefixed_form,
                   input address_offset, input address_length,
                   input port_number, input candidate_kind, output ready);
endinterface

// ===== hdl/ice_candidate_line_parser.sv =====
// ice_candidate_line_parser: top level, byte-serial ICE candidate line parser.
// Depends on iclp_pkg and the interfaces in iclp_if.sv.
//
//   channel   dir  word                          handshake
//   req_bus   in   line_byte[7:0], last_byte     valid/ready
//   rsp_bus   out  status, prefixed_form, address_offset[15:0],
//                  address_length[5:0], port_number[15:0],
//                  candidate_kind[1:0]           valid/ready
//
// One byte is taken per cycle; the parse state updates in the cycle it is
// accepted. The last byte of a line loads the result register, which shows
// the result the next cycle. The input stalls only while a result waits and
// rsp_bus.ready is low. Synchronous reset clears the parse state and the
// result valid; the parse state also returns to reset after every line.

module ice_candidate_line_parser #(
   parameter int ADDRESS_TEXT_LIMIT = 46
) (
   input logic        clock,
   input logic        reset,
   iclp_req_if.sink   req_bus,
   iclp_rsp_if.source rsp_bus
);

   localparam logic [5:0] ADDR_LIMIT = 6'(ADDRESS_TEXT_LIMIT);

   // Parse state
   logic [15:0] byte_position_ff,   byte_position_in;
   logic [3:0]  prefix_progress_ff, prefix_progress_in;
   logic        prefix_failed_ff,   prefix_failed_in;
   logic [3:0]  long_phase_ff,      long_phase_in;
   logic [2:0]  field_count_ff,     field_count_in;
   logic [15:0] long_addr_start_ff, long_addr_start_in;
   logic [5:0]  long_addr_len_ff,   long_addr_len_in;
   logic [15:0] long_port_ff,       long_port_in;
   logic [2:0]  match_index_ff,     match_index_in;
   logic [1:0]  kind_ff,            kind_in;
   logic [1:0]  simple_phase_ff,    simple_phase_in;
   logic [5:0]  simple_addr_len_ff, simple_addr_len_in;
   logic [15:0] simple_port_ff,     simple_port_in;

   // Result register
   logic        rsp_valid_ff;
   logic        rsp_status_ff,   rsp_status_in;
   logic        rsp_prefixed_ff, rsp_prefixed_in;
   logic [15:0] rsp_offset_ff,   rsp_offset_in;
   logic [5:0]  rsp_length_ff,   rsp_length_in;
   logic [15:0] rsp_port_ff,     rsp_port_in;
   logic [1:0]  rsp_kind_ff,     rsp_kind_in;

   logic        req_ready;
   logic        req_accept;
   logic [7:0]  ch;
   logic [15:0] pos_inc;
   logic [1:0]  word_sel;
   logic        tok_ws;
   logic        pref;

   // Handshake: take a word whenever the result register is free or draining
   assign req_ready  = !rsp_valid_ff || rsp_bus.ready;
   assign req_accept = req_bus.valid && req_ready;
   assign req_bus.ready = req_ready;

   assign ch       = req_bus.line_byte;
   assign pos_inc  = iclp_pkg::sat_inc16(byte_position_ff);
   assign word_sel = 2'(long_phase_ff - iclp_pkg::PH_W_HOST);
   assign tok_ws   = iclp_pkg::is_ws(ch);

   // Next parse state for the current byte
   always_comb begin
      byte_position_in   = byte_position_ff;
      prefix_progress_in = prefix_progress_ff;
      prefix_failed_in   = prefix_failed_ff;
      long_phase_in      = long_phase_ff;
      field_count_in     = field_count_ff;
      long_addr_start_in = long_addr_start_ff;
      long_addr_len_in   = long_addr_len_ff;
      long_port_in       = long_port_ff;
      match_index_in     = match_index_ff;
      kind_in            = kind_ff;
      simple_phase_in    = simple_phase_ff;
      simple_addr_len_in = simple_addr_len_ff;
      simple_port_in     = simple_port_ff;

      // Prefix match, then the field walker of the prefixed form
      if (!prefix_failed_ff && (prefix_progress_ff < iclp_pkg::LEAD_LEN)) begin
         if (ch == iclp_pkg::lead_char(prefix_progress_ff)) begin
            prefix_progress_in = 4'(prefix_progress_ff + 4'd1);
            if (prefix_progress_ff == 4'(iclp_pkg::LEAD_LEN - 4'd1)) begin
               long_addr_start_in = pos_inc;
            end
         end else begin
            prefix_failed_in = 1'b1;
         end
      end else if (!prefix_failed_ff) begin
         case (long_phase_ff)
            iclp_pkg::PH_SKIP: begin
               long_addr_start_in = pos_inc;
               if (ch == iclp_pkg::CHAR_SPACE) begin
                  field_count_in = 3'(field_count_ff + 3'd1);
                  long_phase_in  = iclp_pkg::PH_SKIP_SP;
               end
            end
            iclp_pkg::PH_SKIP_SP: begin
               if (ch == iclp_pkg::CHAR_SPACE) begin
                  long_addr_start_in = pos_inc;
               end else if (field_count_ff >= iclp_pkg::ADDR_FIELD) begin
                  long_addr_start_in = byte_position_ff;
                  long_addr_len_in   = 6'd1;
                  long_phase_in      = iclp_pkg::PH_ADDR;
               end else begin
                  long_addr_start_in = pos_inc;
                  long_phase_in      = iclp_pkg::PH_SKIP;
               end
            end
            iclp_pkg::PH_ADDR: begin
               if (ch == iclp_pkg::CHAR_SPACE) begin
                  long_phase_in = iclp_pkg::PH_PORT_SP;
               end else begin
                  long_addr_len_in = iclp_pkg::sat_inc6(long_addr_len_ff);
               end
            end
            iclp_pkg::PH_PORT_SP, iclp_pkg::PH_PORT: begin
               if ((long_phase_ff == iclp_pkg::PH_PORT_SP) && (ch == iclp_pkg::CHAR_SPACE)) begin
                  long_phase_in = long_phase_ff;
               end else if (iclp_pkg::is_digit(ch)) begin
                  long_port_in  = iclp_pkg::port_add(long_port_ff, ch);
                  long_phase_in = iclp_pkg::PH_PORT;
               end else if (tok_ws) begin
                  long_phase_in = iclp_pkg::PH_TOK_START;
               end else if (ch == iclp_pkg::typ_char(3'd0)) begin
                  match_index_in = 3'd1;
                  long_phase_in  = iclp_pkg::PH_TOK_MATCH;
               end else begin
                  long_phase_in = iclp_pkg::PH_TOK_SKIP;
               end
            end
            iclp_pkg::PH_TOK_START: begin
               if (tok_ws) begin
                  long_phase_in = iclp_pkg::PH_TOK_START;
               end else if (ch == iclp_pkg::typ_char(3'd0)) begin
                  match_index_in = 3'd1;
                  long_phase_in  = iclp_pkg::PH_TOK_MATCH;
               end else begin
                  long_phase_in = iclp_pkg::PH_TOK_SKIP;
               end
            end
            iclp_pkg::PH_TOK_MATCH: begin
               if ((match_index_ff < iclp_pkg::TYP_LEN) &&
                   (ch == iclp_pkg::typ_char(match_index_ff))) begin
                  match_index_in = 3'(match_index_ff + 3'd1);
               end else if ((match_index_ff >= iclp_pkg::TYP_LEN) && tok_ws) begin
                  long_phase_in = iclp_pkg::PH_TYPE_WS;
               end else begin
                  long_phase_in = tok_ws ? iclp_pkg::PH_TOK_START : iclp_pkg::PH_TOK_SKIP;
               end
            end
            iclp_pkg::PH_TOK_SKIP: begin
               if (tok_ws) begin
                  long_phase_in = iclp_pkg::PH_TOK_START;
               end
            end
            iclp_pkg::PH_TYPE_WS: begin
               // Leading letters of the type words are distinct
               if (!tok_ws) begin
                  long_phase_in = iclp_pkg::PH_DONE;
                  if (ch == iclp_pkg::word_char(iclp_pkg::WORD_HOST, 3'd0)) begin
                     match_index_in = 3'd1;
                     long_phase_in  = iclp_pkg::PH_W_HOST;
                  end else if (ch == iclp_pkg::word_char(iclp_pkg::WORD_SRFLX, 3'd0)) begin
                     match_index_in = 3'd1;
                     long_phase_in  = iclp_pkg::PH_W_SRFLX;
                  end else if (ch == iclp_pkg::word_char(iclp_pkg::WORD_PRFLX, 3'd0)) begin
                     match_index_in = 3'd1;
                     long_phase_in  = iclp_pkg::PH_W_PRFLX;
                  end else if (ch == iclp_pkg::word_char(iclp_pkg::WORD_RELAY, 3'd0)) begin
                     match_index_in = 3'd1;
                     long_phase_in  = iclp_pkg::PH_W_RELAY;
                  end
               end
            end
            iclp_pkg::PH_W_HOST, iclp_pkg::PH_W_SRFLX,
            iclp_pkg::PH_W_PRFLX, iclp_pkg::PH_W_RELAY: begin
               if ((match_index_ff < iclp_pkg::word_len(word_sel)) &&
                   (ch == iclp_pkg::word_char(word_sel, match_index_ff))) begin
                  match_index_in = 3'(match_index_ff + 3'd1);
                  if (3'(match_index_ff + 3'd1) >= iclp_pkg::word_len(word_sel)) begin
                     kind_in       = iclp_pkg::word_kind(word_sel);
                     long_phase_in = iclp_pkg::PH_DONE;
                  end
               end else begin
                  long_phase_in = iclp_pkg::PH_DONE;
               end
            end
            default: begin
               long_phase_in = iclp_pkg::PH_DONE;
            end
         endcase
      end

      // Simple "<addr> <port>" reading, always running
      case (simple_phase_ff)
         iclp_pkg::SP_ADDR: begin
            if (ch == iclp_pkg::CHAR_SPACE) begin
               simple_phase_in = iclp_pkg::SP_SPACES;
            end else begin
               simple_addr_len_in = iclp_pkg::sat_inc6(simple_addr_len_ff);
            end
         end
         iclp_pkg::SP_SPACES, iclp_pkg::SP_PORT: begin
            if ((simple_phase_ff == iclp_pkg::SP_SPACES) && (ch == iclp_pkg::CHAR_SPACE)) begin
               simple_phase_in = simple_phase_ff;
            end else if (iclp_pkg::is_digit(ch)) begin
               simple_port_in  = iclp_pkg::port_add(simple_port_ff, ch);
               simple_phase_in = iclp_pkg::SP_PORT;
            end else begin
               simple_phase_in = iclp_pkg::SP_DONE;
            end
         end
         default: begin
            simple_phase_in = simple_phase_ff;
         end
      endcase

      byte_position_in = pos_inc;
   end

   // Result word from the updated state
   always_comb begin
      pref = !prefix_failed_in && (prefix_progress_in >= iclp_pkg::LEAD_LEN);
      rsp_prefixed_in = pref;
      if (pref) begin
         rsp_offset_in = long_addr_start_in;
         rsp_length_in = long_addr_len_in;
         rsp_port_in   = long_port_in;
         rsp_kind_in   = kind_in;
      end else begin
         rsp_offset_in = 16'd0;
         rsp_length_in = simple_addr_len_in;
         rsp_port_in   = simple_port_in;
         rsp_kind_in   = iclp_pkg::KIND_HOST;
      end
      rsp_status_in = (rsp_length_in == 6'd0) || (rsp_length_in >= ADDR_LIMIT) ||
                      (rsp_port_in == 16'd0);
   end

   // Parse state registers; cleared at the end of each line
   always_ff @(posedge clock) begin
      if (reset || (req_accept && req_bus.last_byte)) begin
         byte_position_ff   <= 16'd0;
         prefix_progress_ff <= 4'd0;
         prefix_failed_ff   <= 1'b0;
         long_phase_ff      <= iclp_pkg::PH_SKIP;
         field_count_ff     <= 3'd1;
         long_addr_start_ff <= 16'd0;
         long_addr_len_ff   <= 6'd0;
         long_port_ff       <= 16'd0;
         match_index_ff     <= 3'd0;
         kind_ff            <= iclp_pkg::KIND_HOST;
         simple_phase_ff    <= iclp_pkg::SP_ADDR;
         simple_addr_len_ff <= 6'd0;
         simple_port_ff     <= 16'd0;
      end else if (req_accept) begin
         byte_position_ff   <= byte_position_in;
         prefix_progress_ff <= prefix_progress_in;
         prefix_failed_ff   <= prefix_failed_in;
         long_phase_ff      <= long_phase_in;
         field_count_ff     <= field_count_in;
         long_addr_start_ff <= long_addr_start_in;
         long_addr_len_ff   <= long_addr_len_in;
         long_port_ff       <= long_port_in;
         match_index_ff     <= match_index_in;
         kind_ff            <= kind_in;
         simple_phase_ff    <= simple_phase_in;
         simple_addr_len_ff <= simple_addr_len_in;
         simple_port_ff     <= simple_port_in;
      end
   end

   // Result register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept && req_bus.last_byte) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Result register payload
   always_ff @(posedge clock) begin
      if (req_accept && req_bus.last_byte) begin
         rsp_status_ff   <= rsp_status_in;
         rsp_prefixed_ff <= rsp_prefixed_in;
         rsp_offset_ff   <= rsp_offset_in;
         rsp_length_ff   <= rsp_length_in;
         rsp_port_ff     <= rsp_port_in;
         rsp_kind_ff     <= rsp_kind_in;
      end
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.status         = rsp_status_ff;
   assign rsp_bus.prefixed_form  = rsp_prefixed_ff;
   assign rsp_bus.address_offset = rsp_offset_ff;
   assign rsp_bus.address_length = rsp_length_ff;
   assign rsp_bus.port_number    = rsp_port_ff;
   assign rsp_bus.candidate_kind = rsp_kind_ff;

endmodule
